// ===== src/response_line_window_capture_defines.svh =====
// Assertion macros shared by the capture block's checker.
`ifndef RESPONSE_LINE_WINDOW_CAPTURE_DEFINES_SVH
`define RESPONSE_LINE_WINDOW_CAPTURE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high.
`define RLWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst is high.
`define RLWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rlwc_pkg.sv =====
// Character codes and register indexes for the response line window capture block.
package rlwc_pkg;

  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;

  typedef enum logic {
    CFG_START_LINE = 1'b0,
    CFG_END_LINE   = 1'b1
  } cfg_index_t;

endpackage

// ===== src/response_line_window_capture.sv =====
// Response line window capture: top level, one byte in, one buffer write result out.
//
// Input channel (in_valid/in_ready): one received serial byte per beat in rx_byte;
//   arm_record forces recording on before that byte is handled.
// Output channel (out_valid/out_ready): exactly one result beat per input beat, a
//   buffer write request (buf_write, buf_addr, buf_data) with frame_done,
//   prompt_seen and overflow. Drive buf_write straight into the capture buffer's
//   write port when the beat is taken.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes
//   start_line (index 0) and end_line (index 1); always ready, use only while no
//   result is outstanding.
// Timing: the result of a byte sits in the output register on the cycle after
//   its beat. Throughput is one byte per cycle while out_ready stays high; the per-byte
//   work is a handful of byte compares and counter increments.
// Reset: rst clears the counters, the previous byte, the recording flag, both
//   line registers and the output valid flag.
// Stall: while a result waits with out_ready low, in_ready drops and the waiting
//   beat holds; in_ready follows out_ready combinationally, so an output register
//   drained in a cycle takes a new byte in that same cycle.
module response_line_window_capture #(
  parameter int BUF_DEPTH     = 256,
  parameter int PROMPT_WINDOW = 23
) (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       arm_record,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic       buf_write,
  output logic [7:0] buf_addr,
  output logic [7:0] buf_data,
  output logic       frame_done,
  output logic       prompt_seen,
  output logic       overflow,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // Write index is 9 bits, so the usable buffer reach is capped at 512.
  localparam int         LIMIT    = (BUF_DEPTH < 512) ? BUF_DEPTH : 512;
  localparam logic [9:0] LIMIT_W  = 10'(LIMIT);
  localparam logic [15:0] PW_W    = 16'(PROMPT_WINDOW);

  // Configuration registers
  logic [7:0] start_line;
  logic [7:0] end_line;

  // Frame state
  logic [15:0] byte_count;
  logic [8:0]  write_index;
  logic [7:0]  line_count;
  logic [7:0]  prev_byte;
  logic        recording;

  logic [15:0] byte_count_next;
  logic [8:0]  write_index_next;
  logic [7:0]  line_count_next;
  logic [7:0]  prev_byte_next;
  logic        recording_next;

  // Per-byte decode
  logic        in_fire;
  logic        rec_arm;
  logic [15:0] bc_inc;
  logic        is_prompt;
  logic        has_room;
  logic        do_write;
  logic        is_eol;
  logic [7:0]  lc_inc;
  logic [8:0]  stop_line;
  logic        start_hit;
  logic        stop_hit;
  logic        clear_frame;

  logic        buf_write_next;
  logic [7:0]  buf_addr_next;
  logic [7:0]  buf_data_next;
  logic        frame_done_next;
  logic        prompt_seen_next;
  logic        overflow_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line <= '0;
      end_line   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rlwc_pkg::cfg_index_t'(cfg_index))
        rlwc_pkg::CFG_START_LINE: start_line <= cfg_data;
        rlwc_pkg::CFG_END_LINE:   end_line   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // Arming takes effect before the byte is looked at.
    rec_arm   = recording || arm_record;
    bc_inc    = (byte_count != rlwc_pkg::BYTE_COUNT_MAX) ? byte_count + 16'd1 : byte_count;
    is_prompt = (rx_byte == rlwc_pkg::CH_PROMPT) && (bc_inc < PW_W);
    has_room  = {1'b0, write_index} < LIMIT_W;
    do_write  = !is_prompt && rec_arm && has_room;

    // A line ends on LF straight after CR, never on the first byte of a frame.
    is_eol    = !is_prompt && (prev_byte == rlwc_pkg::CH_CR) &&
                (rx_byte == rlwc_pkg::CH_LF) && (bc_inc > 16'd1);
    lc_inc    = line_count + 8'd1;
    stop_line = (end_line == 8'd0) ? {1'b0, start_line} + 9'd1 : {1'b0, end_line} + 9'd1;
    start_hit = is_eol && (lc_inc == start_line) && !rec_arm;
    stop_hit  = is_eol && !start_hit && ({1'b0, lc_inc} == stop_line);
    clear_frame = is_prompt || stop_hit;

    if (clear_frame) begin
      byte_count_next  = '0;
      write_index_next = '0;
      line_count_next  = '0;
      prev_byte_next   = '0;
      recording_next   = 1'b0;
    end else begin
      byte_count_next  = bc_inc;
      write_index_next = do_write ? write_index + 9'd1 : write_index;
      line_count_next  = is_eol ? lc_inc : line_count;
      prev_byte_next   = rx_byte;
      recording_next   = rec_arm || start_hit;
    end

    // Result beat: a prompt always lands at address 0.
    buf_write_next   = is_prompt || do_write;
    buf_addr_next    = do_write ? write_index[7:0] : 8'd0;
    buf_data_next    = is_prompt ? rlwc_pkg::CH_PROMPT : (do_write ? rx_byte : 8'd0);
    frame_done_next  = clear_frame;
    prompt_seen_next = is_prompt;
    overflow_next    = !is_prompt && rec_arm && !has_room;
  end

  // Advance the frame state on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      write_index <= '0;
      line_count  <= '0;
      prev_byte   <= '0;
      recording   <= 1'b0;
    end else if (in_fire) begin
      byte_count  <= byte_count_next;
      write_index <= write_index_next;
      line_count  <= line_count_next;
      prev_byte   <= prev_byte_next;
      recording   <= recording_next;
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_write   <= buf_write_next;
      buf_addr    <= buf_addr_next;
      buf_data    <= buf_data_next;
      frame_done  <= frame_done_next;
      prompt_seen <= prompt_seen_next;
      overflow    <= overflow_next;
    end
  end

endmodule

// ===== src/rlwc_checker.sv =====
// Port-level checker for the response line window capture block, with its bind.
`include "response_line_window_capture_defines.svh"

module rlwc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       buf_write,
  input logic [7:0] buf_addr,
  input logic [7:0] buf_data,
  input logic       frame_done,
  input logic       prompt_seen,
  input logic       overflow
);

  // Every accepted byte yields a result beat on the next cycle.
  `RLWC_ASSERT_NEXT(a_one_result, in_valid && in_ready, out_valid,
    "accepted byte produced no result beat")

  // A waiting result blocks new bytes.
  `RLWC_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
    "byte accepted while a result was stalled")

  // A stalled result holds its payload.
  `RLWC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(buf_write) && $stable(buf_addr) && $stable(buf_data) &&
    $stable(frame_done),
    "stalled result changed")

  // A prompt ends the frame with a '>' written at address 0.
  `RLWC_ASSERT_NOW(a_prompt_beat, out_valid && prompt_seen,
    frame_done && buf_write && (buf_addr == 8'd0) && (buf_data == rlwc_pkg::CH_PROMPT),
    "prompt result malformed")

  // A dropped write never comes with a write strobe.
  `RLWC_ASSERT_NOW(a_overflow_no_write, out_valid && overflow, !buf_write && !prompt_seen,
    "overflow flagged on a written beat")

endmodule

bind response_line_window_capture rlwc_checker u_rlwc_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the response line window capture block.
`timescale 1ns / 1ps

module tb_top;

  localparam int BUF_DEPTH      = 256;
  localparam int PROMPT_WINDOW  = 23;
  localparam int BUF_LIMIT      = (BUF_DEPTH < 512) ? BUF_DEPTH : 512;
  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 400_000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic       buf_write;
    logic [7:0] buf_addr;
    logic [7:0] buf_data;
    logic       frame_done;
    logic       prompt_seen;
    logic       overflow;
  } capture_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       arm_record = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       buf_write;
  logic [7:0] buf_addr;
  logic [7:0] buf_data;
  logic       frame_done;
  logic       prompt_seen;
  logic       overflow;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  // Frame state of the predictor, kept in step with every accepted byte.
  logic [15:0] frame_bytes;
  logic [8:0]  buf_fill;
  logic [7:0]  lines_seen;
  logic [7:0]  last_rx;
  logic        capturing;
  // Line window as last written to the block.
  logic [7:0]  win_start;
  logic [7:0]  win_end;

  // Results owed by the block, oldest first.
  capture_result_t due_captures[$];

  int send_gap_pct = 0;   // chance in a hundred of an idle cycle before a byte
  int stall_pct    = 0;   // chance in a hundred of out_ready low on a cycle
  int beats_sent   = 0;
  int mismatch_count = 0;

  response_line_window_capture #(
    .BUF_DEPTH    (BUF_DEPTH),
    .PROMPT_WINDOW(PROMPT_WINDOW)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .arm_record (arm_record),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .buf_write  (buf_write),
    .buf_addr   (buf_addr),
    .buf_data   (buf_data),
    .frame_done (frame_done),
    .prompt_seen(prompt_seen),
    .overflow   (overflow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Receiver back-pressure: redraw out_ready on every edge.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop everything a finished frame leaves behind.
  function automatic void clear_frame();
    capturing   = 1'b0;
    buf_fill    = '0;
    frame_bytes = '0;
    lines_seen  = '0;
    last_rx     = '0;
  endfunction

  // Advance the frame state by one byte and return the beat it must produce.
  function automatic capture_result_t predict_capture(logic [7:0] rx, logic arm);
    capture_result_t r;
    logic [8:0]      stop_at;
    r = '0;
    if (arm) capturing = 1'b1;
    if (frame_bytes != rlwc_pkg::BYTE_COUNT_MAX) frame_bytes = frame_bytes + 16'd1;

    // An early prompt wins over everything else: write it at the head and restart.
    if (rx == rlwc_pkg::CH_PROMPT && frame_bytes < PROMPT_WINDOW) begin
      r.buf_write   = 1'b1;
      r.buf_addr    = 8'h00;
      r.buf_data    = rlwc_pkg::CH_PROMPT;
      r.frame_done  = 1'b1;
      r.prompt_seen = 1'b1;
      clear_frame();
    end else begin
      if (capturing) begin
        if (buf_fill < BUF_LIMIT) begin
          r.buf_write = 1'b1;
          r.buf_addr  = buf_fill[7:0];
          r.buf_data  = rx;
          buf_fill    = buf_fill + 9'd1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      // A line ends on LF straight after CR; the ending byte was written above.
      if (last_rx == rlwc_pkg::CH_CR && rx == rlwc_pkg::CH_LF && frame_bytes > 16'd1) begin
        lines_seen = lines_seen + 8'd1;
        if (lines_seen == win_start && !capturing) begin
          capturing = 1'b1;
        end else begin
          // Nine-bit compare, so a window edge of 255 never closes the frame.
          stop_at = (win_end == 8'd0) ? {1'b0, win_start} + 9'd1 : {1'b0, win_end} + 9'd1;
          if ({1'b0, lines_seen} == stop_at) begin
            r.frame_done = 1'b1;
            clear_frame();
          end
        end
      end
      if (!r.frame_done) last_rx = rx;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic string beat_text(capture_result_t b);
    return $sformatf("wr=%0d addr=%02h data=%02h done=%0d prompt=%0d ovf=%0d",
                     b.buf_write, b.buf_addr, b.buf_data, b.frame_done,
                     b.prompt_seen, b.overflow);
  endfunction

  // Compare every result beat with the oldest one owed; values are the pre-edge ones.
  always @(posedge clk) begin : check_results
    capture_result_t seen;
    capture_result_t owed;
    if (!rst && out_valid && out_ready) begin
      seen.buf_write   = buf_write;
      seen.buf_addr    = buf_addr;
      seen.buf_data    = buf_data;
      seen.frame_done  = frame_done;
      seen.prompt_seen = prompt_seen;
      seen.overflow    = overflow;
      if (due_captures.size() == 0) begin
        if (mismatch_count < 10)
          $display("[%0t] capture result with nothing owed: got %s", $realtime,
                   beat_text(seen));
        mismatch_count++;
      end else begin
        owed = due_captures.pop_front();
        if (seen !== owed) begin
          if (mismatch_count < 10)
            $display("[%0t] capture mismatch: expected %s, got %s", $realtime,
                     beat_text(owed), beat_text(seen));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the beat is taken, then record what it owes.
  // Valid stays high on return so back-to-back bytes need no extra edge.
  task automatic send_byte(logic [7:0] rx, logic arm);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= rx;
    arm_record <= arm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_captures.push_back(predict_capture(rx, arm));
    beats_sent++;
  endtask

  // Drop valid and wait for every owed result, plus the output register's latency.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_captures.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both line registers back to back; only call while the block is idle.
  task automatic set_line_window(logic [7:0] first_line, logic [7:0] last_line);
    cfg_valid <= 1'b1;
    cfg_index <= rlwc_pkg::CFG_START_LINE;
    cfg_data  <= first_line;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_start = first_line;
    cfg_index <= rlwc_pkg::CFG_END_LINE;
    cfg_data  <= last_line;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_end = last_line;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic arm_now();
    return ($urandom_range(99) < 3);
  endfunction

  // Mostly printable text, some raw bytes; push a prompt onto the window edge now and then.
  function automatic logic [7:0] pick_content();
    if (frame_bytes >= 16'd20 && frame_bytes <= 16'd22 && $urandom_range(99) < 20)
      return rlwc_pkg::CH_PROMPT;
    if ($urandom_range(99) < 75) return 8'($urandom_range(8'h7E, 8'h20));
    return 8'($urandom_range(255));
  endfunction

  // Stream modem-style responses: mostly CR-LF lines of random text, with some
  // torn line endings and raw noise mixed in.
  task automatic stream_responses(int goal);
    int kind;
    int len;
    int stop_at;
    stop_at = beats_sent + goal;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = $urandom_range(6);
        repeat (len) send_byte(pick_content(), arm_now());
        send_byte(rlwc_pkg::CH_CR, arm_now());
        send_byte(rlwc_pkg::CH_LF, arm_now());
      end else if (kind < 95) begin
        case ($urandom_range(2))
          0: begin
            send_byte(rlwc_pkg::CH_CR, arm_now());
            send_byte(pick_content(), arm_now());
          end
          1: send_byte(rlwc_pkg::CH_LF, arm_now());
          default: begin
            send_byte(rlwc_pkg::CH_CR, arm_now());
            send_byte(rlwc_pkg::CH_CR, arm_now());
            send_byte(rlwc_pkg::CH_LF, arm_now());
          end
        endcase
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) send_byte(8'($urandom_range(255)), arm_now());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked frames: prompt, armed capture, line endings, window start.
  task automatic test_directed_frames();
    set_line_window(8'd0, 8'd0);
    send_byte(rlwc_pkg::CH_PROMPT, 1'b0);  // prompt on the first byte
    send_byte(8'h00, 1'b1);                // arm: capture from address 0
    send_byte(8'hFF, 1'b0);
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);      // ending byte still written, frame closes
    send_byte(8'h41, 1'b0);                // unarmed line closes without writes
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    send_byte(8'h55, 1'b1);                // prompt cuts an armed capture short
    send_byte(rlwc_pkg::CH_PROMPT, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);      // LF with no CR before it is no line
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    settle();

    // Capture begins on reaching line two and ends one line later.
    set_line_window(8'd2, 8'd0);
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    settle();
  endtask

  // End line zero: window of one line after the start line.
  task automatic test_single_line_window();
    set_line_window(8'($urandom_range(3, 1)), 8'd0);
    stream_responses(40);
    settle();
  endtask

  // Explicit end line beyond the start line.
  task automatic test_multi_line_window();
    logic [7:0] first_line;
    first_line = 8'($urandom_range(3, 1));
    set_line_window(first_line, first_line + 8'($urandom_range(4, 1)));
    stream_responses(40);
    settle();
  endtask

  // End line below the start line: frames close before capture can begin.
  task automatic test_end_before_start();
    set_line_window(8'($urandom_range(5, 3)), 8'($urandom_range(2, 1)));
    stream_responses(40);
    settle();
  endtask

  // One long frame: the buffer fills and the line count wraps, so a late prompt
  // is plain data; a last window write then closes the frame.
  task automatic test_counter_limits();
    int         i;
    logic [7:0] b;
    set_line_window(8'd255, 8'd255);
    send_byte(8'h41, 1'b1);
    for (i = 0; i < 512; i++) begin
      b = (i % 2 == 0) ? rlwc_pkg::CH_CR : rlwc_pkg::CH_LF;
      send_byte(b, $urandom_range(99) < 2);
    end
    send_byte(rlwc_pkg::CH_PROMPT, 1'b0);
    // Steer off the line values that cannot serve as a closing window.
    while (lines_seen == 8'hFF || lines_seen == 8'h00) begin
      send_byte(rlwc_pkg::CH_CR, 1'b0);
      send_byte(rlwc_pkg::CH_LF, 1'b0);
    end
    settle();
    // Close the frame on the very next line.
    set_line_window(8'd255, lines_seen);
    send_byte(rlwc_pkg::CH_CR, 1'b0);
    send_byte(rlwc_pkg::CH_LF, 1'b0);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    win_start = '0;
    win_end   = '0;
    clear_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Light sender gaps, heavy receiver stalls.
    send_gap_pct = 13;
    stall_pct    = 59;
    test_directed_frames();
    test_single_line_window();

    // Heavy sender gaps, light receiver stalls.
    send_gap_pct = 59;
    stall_pct    = 13;
    test_multi_line_window();

    // Full rate on both sides.
    send_gap_pct = 0;
    stall_pct    = 0;
    test_end_before_start();
    test_counter_limits();

    if (mismatch_count == 0 && due_captures.size() == 0) begin
      $display("response_line_window_capture verification clean");
    end else begin
      $display("response_line_window_capture verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("response_line_window_capture verification failed");
    $finish;
  end

endmodule
